### hw/rtl/evq_pkg.sv
// shared constants and codes for the event queue with button coalescing
package evq_pkg;

    localparam int unsigned DEPTH_DEF = 256;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned KIND_W = 4;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned KC_W   = KIND_W + CODE_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_BUTTON = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd4;

    // event kinds with a meaning to the queue
    localparam logic [KIND_W-1:0] KIND_NONE = 4'd0;
    localparam logic [KIND_W-1:0] KIND_DOWN = 4'd1;
    localparam logic [KIND_W-1:0] KIND_UP   = 4'd2;

endpackage

### hw/rtl/evq_ifs.sv
// request and response channel interfaces of the event queue
interface evq_req_if;
    import evq_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [KIND_W-1:0]   event_kind;
    logic [CODE_W-1:0]   key_code;
    logic [DATA_W-1:0]   event_payload;
    logic [DATA_W-1:0]   time_now;

    modport source (
        output valid, command, event_kind, key_code, event_payload, time_now,
        input  ready
    );
    modport sink (
        input  valid, command, event_kind, key_code, event_payload, time_now,
        output ready
    );
endinterface

interface evq_rsp_if;
    import evq_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic [KIND_W-1:0]   out_kind;
    logic [CODE_W-1:0]   out_code;
    logic [DATA_W-1:0]   out_payload;
    logic [DATA_W-1:0]   out_stamp;

    modport source (
        output valid, accepted, out_kind, out_code, out_payload, out_stamp,
        input  ready
    );
    modport sink (
        input  valid, accepted, out_kind, out_code, out_payload, out_stamp,
        output ready
    );
endinterface

### hw/rtl/event_fifo_with_button_coalescing.sv
// top level: circular event queue with button edge coalescing
//
//  channel   dir  signals                                          request
//  i_req     in   command event_kind key_code event_payload time_now  one command
//  o_rsp     out  accepted out_kind out_code out_payload out_stamp     one result
//
// one command at a time; put, flush and unused codes go straight to the result step,
// get and peek make one ram read, put_button two when a stale pair may need checking,
// since both newest kind/code entries come out of one ram read port in turn
// reset clears the pointers and the control state; the rams are not cleared
// a held result in the output register does not block the next request;
// only the final step of a command waits for the output register to free up
module event_fifo_with_button_coalescing #(
    parameter int unsigned DEPTH = evq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    evq_req_if.sink   i_req,
    evq_rsp_if.source o_rsp
);
    import evq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_PB1,
        S_PB2,
        S_RESP
    } t_state;

    // outcome of storing one event
    typedef struct packed {
        logic          acc;
        logic          we;
        logic [AW-1:0] wp;
    } t_store;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    // kind none is ignored but reported as success; full drops the event
    function automatic t_store store_event(
        input logic [KIND_W-1:0] kind,
        input logic [AW-1:0]     base,
        input logic [AW-1:0]     rp
    );
        t_store s;
        s.acc = 1'b1;
        s.we  = 1'b0;
        s.wp  = base;
        if (kind != KIND_NONE) begin
            if (ptr_next(base) == rp) begin
                s.acc = 1'b0;
            end else begin
                s.we = 1'b1;
                s.wp = ptr_next(base);
            end
        end
        return s;
    endfunction

    // control registers
    t_state        r_state, n_state;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_ovalid, n_ovalid;

    // latched request and pending result
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [CODE_W-1:0] r_code, n_code;
    logic [DATA_W-1:0] r_payload, n_payload;
    logic [DATA_W-1:0] r_now, n_now;
    logic [AW-1:0]     r_p1, n_p1;
    logic              r_m1, n_m1;
    logic              r_acc, n_acc;
    logic [KIND_W-1:0] r_rkind, n_rkind;
    logic [CODE_W-1:0] r_rcode, n_rcode;
    logic [DATA_W-1:0] r_rpay, n_rpay;
    logic [DATA_W-1:0] r_rstamp, n_rstamp;

    // output register
    logic              r_oacc, n_oacc;
    logic [KIND_W-1:0] r_okind, n_okind;
    logic [CODE_W-1:0] r_ocode, n_ocode;
    logic [DATA_W-1:0] r_opay, n_opay;
    logic [DATA_W-1:0] r_ostamp, n_ostamp;

    // ram ports
    logic                kc_we;
    logic [AW-1:0]       kc_waddr;
    logic [KC_W-1:0]     kc_wdata;
    logic [AW-1:0]       kc_raddr;
    logic [KC_W-1:0]     kc_rdata;
    logic [2*DATA_W-1:0] dt_wdata;
    logic [AW-1:0]       dt_raddr;
    logic [2*DATA_W-1:0] dt_rdata;

    logic              accept;
    logic              out_free;
    logic              is_button;
    logic [KIND_W-1:0] opp_kind;
    logic              match2;
    t_store            st;

    // kind and code share one ram, payload and stamp the other
    evq_ram #(
        .WIDTH (KC_W),
        .DEPTH (DEPTH)
    ) u_kc_ram (
        .i_clk   (i_clk),
        .i_we    (kc_we),
        .i_waddr (kc_waddr),
        .i_wdata (kc_wdata),
        .i_raddr (kc_raddr),
        .o_rdata (kc_rdata)
    );

    evq_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (kc_we),
        .i_waddr (kc_waddr),
        .i_wdata (dt_wdata),
        .i_raddr (dt_raddr),
        .o_rdata (dt_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;

    assign is_button = (i_req.event_kind == KIND_DOWN) || (i_req.event_kind == KIND_UP);
    assign opp_kind  = (r_kind == KIND_DOWN) ? KIND_UP : KIND_DOWN;
    assign match2    = (kc_rdata[KIND_W-1:0] == r_kind) && (kc_rdata[KC_W-1:KIND_W] == r_code);

    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_ovalid  = r_ovalid;
        n_cmd     = r_cmd;
        n_kind    = r_kind;
        n_code    = r_code;
        n_payload = r_payload;
        n_now     = r_now;
        n_p1      = r_p1;
        n_m1      = r_m1;
        n_acc     = r_acc;
        n_rkind   = r_rkind;
        n_rcode   = r_rcode;
        n_rpay    = r_rpay;
        n_rstamp  = r_rstamp;
        n_oacc    = r_oacc;
        n_okind   = r_okind;
        n_ocode   = r_ocode;
        n_opay    = r_opay;
        n_ostamp  = r_ostamp;

        // write side: new request in idle, latched request after the pair check
        kc_we    = 1'b0;
        kc_waddr = r_wp;
        kc_wdata = {r_code, r_kind};
        dt_wdata = {r_payload, r_now};
        kc_raddr = r_rp;
        dt_raddr = r_rp;
        st       = store_event(r_kind, r_wp, r_rp);

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = i_req.command;
                    n_kind    = i_req.event_kind;
                    n_code    = i_req.key_code;
                    n_payload = i_req.event_payload;
                    n_now     = i_req.time_now;
                    n_acc     = 1'b0;
                    n_rkind   = '0;
                    n_rcode   = '0;
                    n_rpay    = '0;
                    n_rstamp  = '0;
                    n_state   = S_RESP;
                    kc_wdata  = {i_req.key_code, i_req.event_kind};
                    dt_wdata  = {i_req.event_payload, i_req.time_now};
                    st        = store_event(i_req.event_kind, r_wp, r_rp);
                    case (i_req.command)
                        CMD_PUT: begin
                            kc_we = st.we;
                            n_acc = st.acc;
                            n_wp  = st.wp;
                        end
                        CMD_PUT_BUTTON: begin
                            // pair check needs at least two queued entries
                            if (is_button && (r_rp != r_wp) && (ptr_prev(r_wp) != r_rp)) begin
                                kc_raddr = ptr_prev(r_wp);
                                n_p1     = ptr_prev(r_wp);
                                n_state  = S_PB1;
                            end else begin
                                kc_we = st.we;
                                n_acc = st.acc;
                                n_wp  = st.wp;
                            end
                        end
                        CMD_GET, CMD_PEEK: begin
                            n_state = S_GET;
                        end
                        CMD_FLUSH: begin
                            n_rp = '0;
                            n_wp = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_GET: begin
                // empty queue answers all zeros, already set at accept
                if (r_rp != r_wp) begin
                    n_rkind  = kc_rdata[KIND_W-1:0];
                    n_rcode  = kc_rdata[KC_W-1:KIND_W];
                    n_rpay   = dt_rdata[2*DATA_W-1:DATA_W];
                    n_rstamp = dt_rdata[DATA_W-1:0];
                    if (r_cmd == CMD_GET) begin
                        n_rp = ptr_next(r_rp);
                    end
                end
                n_state = S_RESP;
            end
            S_PB1: begin
                // newest entry must be the opposite edge of the same button
                n_m1 = (kc_rdata[KIND_W-1:0] == opp_kind) &&
                       (kc_rdata[KC_W-1:KIND_W] == r_code);
                kc_raddr = ptr_prev(r_p1);
                n_state  = S_PB2;
            end
            S_PB2: begin
                // the one before must be the same edge; then drop both
                if (r_m1 && match2) begin
                    st       = store_event(r_kind, ptr_prev(r_p1), r_rp);
                    kc_waddr = ptr_prev(r_p1);
                end
                kc_we   = st.we;
                n_acc   = st.acc;
                n_wp    = st.wp;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oacc   = r_acc;
                    n_okind  = r_rkind;
                    n_ocode  = r_rcode;
                    n_opay   = r_rpay;
                    n_ostamp = r_rstamp;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_ovalid <= n_ovalid;
        end
    end

    // request, result and output payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_kind    <= n_kind;
        r_code    <= n_code;
        r_payload <= n_payload;
        r_now     <= n_now;
        r_p1      <= n_p1;
        r_m1      <= n_m1;
        r_acc     <= n_acc;
        r_rkind   <= n_rkind;
        r_rcode   <= n_rcode;
        r_rpay    <= n_rpay;
        r_rstamp  <= n_rstamp;
        r_oacc    <= n_oacc;
        r_okind   <= n_okind;
        r_ocode   <= n_ocode;
        r_opay    <= n_opay;
        r_ostamp  <= n_ostamp;
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.accepted    = r_oacc;
    assign o_rsp.out_kind    = r_okind;
    assign o_rsp.out_code    = r_ocode;
    assign o_rsp.out_payload = r_opay;
    assign o_rsp.out_stamp   = r_ostamp;
endmodule

### hw/rtl/evq_ram.sv
// generic simple dual port ram, one write port, one registered read port
module evq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### verif/tb.sv
// testbench for the event queue: directed and random commands checked against a queue model
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import evq_pkg::*;

    // pointer width of the queue, pointers wrap by overflow
    localparam int unsigned PTR_W = $clog2(DEPTH_DEF);

    // command codes with no function, the block must answer with all zeros
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // kinds with no button meaning
    localparam logic [KIND_W-1:0] KIND_MAX   = 4'hF;
    localparam logic [KIND_W-1:0] KIND_PLAIN = 4'd9;

    localparam int unsigned HOLD_CYCLES = 80;   // long output stall in the pressure test
    localparam int unsigned DRAIN_LEVEL = 16;   // drain phase stops below this fill level
    localparam int unsigned DRAIN_CAP   = 600;  // upper bound of drain phase iterations
    localparam int unsigned TAIL_CYCLES = 10;   // quiet cycles after the last result

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] now;
    } t_evq_request;

    typedef struct packed {
        logic              accepted;
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] stamp;
    } t_evq_result;

    logic i_clk;
    logic i_rst_n;

    evq_req_if req_if();
    evq_rsp_if rsp_if();

    event_fifo_with_button_coalescing #(
        .DEPTH (DEPTH_DEF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // ------------------------------------------------------------------
    // queue model: slot contents plus head (oldest) and tail (next free)
    // ------------------------------------------------------------------
    logic [KIND_W-1:0] slot_kind    [DEPTH_DEF];
    logic [CODE_W-1:0] slot_code    [DEPTH_DEF];
    logic [DATA_W-1:0] slot_payload [DEPTH_DEF];
    logic [DATA_W-1:0] slot_stamp   [DEPTH_DEF];
    logic [PTR_W-1:0]  head_ptr;
    logic [PTR_W-1:0]  tail_ptr;

    t_evq_result expected_results[$];   // one entry per accepted request, oldest first

    int          error_count;
    int unsigned requests_sent;
    bit          idle_on;           // random gaps and stalls enabled
    int unsigned rsp_hold_cycles;   // nonzero asks the receiver for one long stall

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic int unsigned queue_level();
        logic [PTR_W-1:0] diff;
        diff = tail_ptr - head_ptr;
        return int'(diff);
    endfunction

    // store one event at the tail, kind none is a no-op that still succeeds
    function automatic logic store_event(t_evq_request rq);
        logic [PTR_W-1:0] next_tail;
        next_tail = tail_ptr + 1'b1;
        if (rq.kind == KIND_NONE) begin
            return 1'b1;
        end
        if (next_tail == head_ptr) begin
            return 1'b0;   // full, event dropped
        end
        slot_kind[tail_ptr]    = rq.kind;
        slot_code[tail_ptr]    = rq.code;
        slot_payload[tail_ptr] = rq.payload;
        slot_stamp[tail_ptr]   = rq.now;
        tail_ptr               = next_tail;
        return 1'b1;
    endfunction

    // advance the model by one request and return the result it must give
    function automatic t_evq_result apply_request(t_evq_request rq);
        t_evq_result      res;
        logic [PTR_W-1:0] newest;
        logic [PTR_W-1:0] second;
        logic [KIND_W-1:0] opposite;
        res = '0;
        case (rq.cmd)
            CMD_PUT: begin
                res.accepted = store_event(rq);
            end
            CMD_PUT_BUTTON: begin
                // a stale press/release pair of the same key is cancelled first
                if ((rq.kind == KIND_DOWN || rq.kind == KIND_UP) && head_ptr != tail_ptr) begin
                    opposite = (rq.kind == KIND_DOWN) ? KIND_UP : KIND_DOWN;
                    newest   = tail_ptr - 1'b1;
                    if (newest != head_ptr) begin
                        second = newest - 1'b1;
                        if (slot_kind[newest] == opposite && slot_code[newest] == rq.code &&
                            slot_kind[second] == rq.kind && slot_code[second] == rq.code) begin
                            tail_ptr = second;
                        end
                    end
                end
                res.accepted = store_event(rq);
            end
            CMD_GET, CMD_PEEK: begin
                if (head_ptr != tail_ptr) begin
                    res.kind    = slot_kind[head_ptr];
                    res.code    = slot_code[head_ptr];
                    res.payload = slot_payload[head_ptr];
                    res.stamp   = slot_stamp[head_ptr];
                    if (rq.cmd == CMD_GET) begin
                        head_ptr = head_ptr + 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                head_ptr = '0;
                tail_ptr = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_evq_request make_request(logic [CMD_W-1:0] cmd,
                                                  logic [KIND_W-1:0] kind,
                                                  logic [CODE_W-1:0] code);
        t_evq_request rq;
        rq.cmd     = cmd;
        rq.kind    = kind;
        rq.code    = code;
        rq.payload = $urandom;
        rq.now     = $urandom;
        return rq;
    endfunction

    // drive one request at falling edges, hold it until the block takes it,
    // then record what the block must answer
    task automatic send_request(t_evq_request rq);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.command       <= rq.cmd;
        req_if.event_kind    <= rq.kind;
        req_if.key_code      <= rq.code;
        req_if.event_payload <= rq.payload;
        req_if.time_now      <= rq.now;
        do @(posedge i_clk);
        while (!req_if.ready);
        expected_results.push_back(apply_request(rq));
        requests_sent++;
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [KIND_W-1:0] kind,
                            logic [CODE_W-1:0] code);
        send_request(make_request(cmd, kind, code));
    endtask

    // a run of alternating key edges on one code; mostly clean, so the
    // coalescing fires often, with the odd wrong code or repeated edge
    task automatic send_button_burst();
        logic [CODE_W-1:0] code;
        logic [KIND_W-1:0] pol;
        int unsigned       len;
        int unsigned       twist;
        code = CODE_W'($urandom);
        pol  = ($urandom_range(0, 1) == 0) ? KIND_DOWN : KIND_UP;
        len  = $urandom_range(2, 6);
        repeat (len) begin
            twist = $urandom_range(0, 19);
            send_cmd(($urandom_range(0, 4) == 0) ? CMD_PUT : CMD_PUT_BUTTON, pol,
                     (twist == 0) ? (code ^ CODE_W'(1)) : code);
            if (twist != 1) begin
                pol = (pol == KIND_DOWN) ? KIND_UP : KIND_DOWN;
            end
        end
    endtask

    // one random step: reads at the given share, the rest puts, bursts and noise
    task automatic send_random_step(int unsigned get_pct, bit flush_ok);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < get_pct) begin
            send_cmd(($urandom_range(0, 3) == 0) ? CMD_PEEK : CMD_GET,
                     KIND_W'($urandom), CODE_W'($urandom));
        end else if (pick < get_pct + 3) begin
            send_cmd(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                     KIND_W'($urandom), CODE_W'($urandom));
        end else if (pick < get_pct + 5 && flush_ok) begin
            send_cmd(CMD_FLUSH, KIND_W'($urandom), CODE_W'($urandom));
        end else if (pick < get_pct + 5 + (100 - get_pct) / 3) begin
            send_cmd(($urandom_range(0, 3) == 0) ? CMD_PUT_BUTTON : CMD_PUT,
                     KIND_W'($urandom), CODE_W'($urandom));
        end else begin
            send_button_burst();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every command once, empty reads, kind none, field extremes and the
    // coalescing rules one by one
    task automatic test_directed_commands();
        t_evq_request rq;
        send_cmd(CMD_PEEK, KIND_NONE, '0);            // empty queue reads give zeros
        send_cmd(CMD_GET, KIND_NONE, '0);
        send_cmd(CMD_PUT, KIND_NONE, 8'h33);          // kind none: nothing stored, success
        send_cmd(CMD_PUT_BUTTON, KIND_NONE, 8'h33);
        rq         = make_request(CMD_PUT, KIND_MAX, '1);
        rq.payload = '1;
        rq.now     = '1;
        send_request(rq);                             // all ones
        rq         = make_request(CMD_PUT, KIND_DOWN, '0);
        rq.payload = '0;
        rq.now     = '0;
        send_request(rq);                             // all zeros apart from the kind
        send_cmd(CMD_PEEK, KIND_NONE, '0);
        send_cmd(CMD_GET, KIND_NONE, '0);
        send_cmd(CMD_GET, KIND_NONE, '0);
        send_cmd(CMD_GET, KIND_NONE, '0);             // empty again
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
            send_cmd(CMD_W'(c), KIND_DOWN, 8'h5A);
        end
        send_cmd(CMD_PUT_BUTTON, KIND_PLAIN, 8'h5A);  // non-button kind, plain put
        send_cmd(CMD_PUT_BUTTON, KIND_DOWN, 8'h5A);   // newest is not a button edge
        send_cmd(CMD_PUT_BUTTON, KIND_UP, 8'h5A);     // older entry is the wrong kind
        send_cmd(CMD_PUT_BUTTON, KIND_DOWN, 8'h5A);   // down/up pair cancelled
        send_cmd(CMD_PUT_BUTTON, KIND_UP, 8'h5B);     // other key
        send_cmd(CMD_PUT_BUTTON, KIND_DOWN, 8'h5A);   // code mismatch, no cancel
        send_cmd(CMD_FLUSH, KIND_NONE, '0);
        send_cmd(CMD_PUT, KIND_DOWN, 8'h11);          // pair written by plain puts
        send_cmd(CMD_PUT, KIND_UP, 8'h11);
        send_cmd(CMD_PUT_BUTTON, KIND_DOWN, 8'h11);
        send_cmd(CMD_GET, KIND_NONE, '0);
        send_cmd(CMD_GET, KIND_NONE, '0);
    endtask

    // the receiver stalls for a long stretch while requests keep coming
    // back to back, so the output register fills and the input stalls
    task automatic test_output_backpressure();
        idle_on         = 1'b0;
        rsp_hold_cycles = HOLD_CYCLES;
        repeat (6) begin
            send_cmd(CMD_PUT, KIND_W'($urandom_range(1, KIND_MAX)), CODE_W'($urandom));
            send_cmd(CMD_GET, KIND_NONE, '0);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_mix(int unsigned count);
        int unsigned stop_at;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 39) == 0) begin
                idle_on = !idle_on;   // stretches without any idling
            end
            send_random_step(35, 1'b1);
        end
        idle_on = 1'b1;
    endtask

    // fill to the brim: the tail crosses the wrap point on the way, a
    // cancellation frees room in a full queue, then puts bounce off
    task automatic test_full_queue();
        logic [CODE_W-1:0] code;
        code = CODE_W'($urandom);
        while (queue_level() < DEPTH_DEF - 3) begin
            if ($urandom_range(0, 49) == 0) begin
                idle_on = !idle_on;
            end
            send_cmd(CMD_PUT, KIND_W'($urandom_range(1, KIND_MAX)), CODE_W'($urandom));
        end
        send_cmd(CMD_PUT, KIND_DOWN, code);
        send_cmd(CMD_PUT, KIND_UP, code);                    // now full
        send_cmd(CMD_PUT_BUTTON, KIND_DOWN, code);           // cancel makes room
        send_cmd(CMD_PUT, KIND_W'($urandom_range(1, KIND_MAX)), CODE_W'($urandom));
        repeat (2) begin
            send_cmd(CMD_PUT, KIND_W'($urandom_range(1, KIND_MAX)), CODE_W'($urandom));
        end
        send_cmd(CMD_PUT_BUTTON, KIND_PLAIN, CODE_W'($urandom));
        send_cmd(CMD_PUT, KIND_NONE, CODE_W'($urandom));     // none still succeeds
        send_cmd(CMD_PEEK, KIND_NONE, '0);
        idle_on = 1'b1;
    endtask

    // read-heavy traffic until the head has wrapped and the queue is low (or the
    // step cap is hit), then empty it and read once more on the empty queue
    task automatic test_drain_with_wrap();
        logic [PTR_W-1:0] prev_head;
        bit               wrapped;
        int unsigned      steps;
        wrapped = 1'b0;
        steps   = 0;
        while (!(wrapped && queue_level() < DRAIN_LEVEL) && steps < DRAIN_CAP) begin
            prev_head = head_ptr;
            send_random_step(95, 1'b0);
            if (head_ptr < prev_head) begin
                wrapped = 1'b1;
            end
            steps++;
        end
        while (queue_level() != 0) begin
            send_cmd(CMD_GET, KIND_W'($urandom), CODE_W'($urandom));
        end
        send_cmd(CMD_GET, KIND_NONE, '0);
    endtask

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------

    // ready: a random stall before each result, or one long hold on request
    initial begin : rsp_ready_driver
        int unsigned stall;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(negedge i_clk);
                rsp_hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 5) : 0;
                if (stall != 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(rsp_if.valid && rsp_if.ready) && rsp_hold_cycles == 0);
        end
    end

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    // each result taken is compared with the oldest outstanding expectation
    always @(posedge i_clk) begin : result_checker
        t_evq_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("accepted", DATA_W'(want.accepted), DATA_W'(rsp_if.accepted));
                check_field("out_kind", DATA_W'(want.kind), DATA_W'(rsp_if.out_kind));
                check_field("out_code", DATA_W'(want.code), DATA_W'(rsp_if.out_code));
                check_field("out_payload", want.payload, rsp_if.out_payload);
                check_field("out_stamp", want.stamp, rsp_if.out_stamp);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.command       = CMD_PUT;
        req_if.event_kind    = KIND_NONE;
        req_if.key_code      = '0;
        req_if.event_payload = '0;
        req_if.time_now      = '0;
        head_ptr             = '0;
        tail_ptr             = '0;
        error_count          = 0;
        requests_sent        = 0;
        idle_on              = 1'b1;
        rsp_hold_cycles      = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_commands();
        test_output_backpressure();
        test_random_mix(40);
        test_full_queue();
        test_drain_with_wrap();

        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // wait for the last results, then idle on for TAIL_CYCLES to catch strays
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
